// ===== rtl/core/spl_pkg.sv =====
`default_nettype none
// ============================================================================
// spl_pkg: shared types and constants of the STX/ETX packet link
// Symbol codes, command codes, event codes and the transaction structs that
// travel between the link front end, the job queue and the transmit back end.
// ============================================================================
package spl_pkg;

   // Framing symbols.
   localparam logic [7:0] SYM_DLE = 8'd40;
   localparam logic [7:0] SYM_STX = 8'd41;
   localparam logic [7:0] SYM_ETX = 8'd126;

   // Command codes.
   localparam logic [7:0] CMD_HEARTBEAT = 8'd0;
   localparam logic [7:0] CMD_ECHO      = 8'd1;
   localparam logic [7:0] CMD_PWM_FIRST = 8'd2;
   localparam logic [7:0] CMD_ERROR     = 8'd11;
   localparam logic [7:0] ERR_MALFORMED = 8'd1;

   // Input actions.
   localparam logic [1:0] ACT_RX   = 2'd0;
   localparam logic [1:0] ACT_PWM  = 2'd1;
   localparam logic [1:0] ACT_BEAT = 2'd2;

   // Event codes reported on every result.
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_SYNC    = 3'd1;
   localparam logic [2:0] EV_FRAME   = 3'd2;
   localparam logic [2:0] EV_CSUM    = 3'd3;
   localparam logic [2:0] EV_PEER    = 3'd4;
   localparam logic [2:0] EV_UNKNOWN = 3'd5;

   // Byte positions of an outgoing six-byte packet.
   localparam logic [2:0] POS_STX  = 3'd0;
   localparam logic [2:0] POS_P1   = 3'd1;
   localparam logic [2:0] POS_P2   = 3'd2;
   localparam logic [2:0] POS_CMD  = 3'd3;
   localparam logic [2:0] POS_SUM  = 3'd4;
   localparam logic [2:0] POS_LAST = 3'd5;

   // Number of payload bytes collected after STX before the ETX position.
   localparam logic [2:0] FRAME_DATA = 3'd4;

   // Receive framing state.
   typedef enum logic {
      ST_HUNT,
      ST_COLLECT
   } link_state_type;

   // What the back end has to send for one job.
   typedef enum logic [1:0] {
      JOB_EVENT,
      JOB_PACKET,
      JOB_PAD
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [2:0]   res;
      logic [7:0]   p1;
      logic [7:0]   p2;
      logic [7:0]   cmd;
   } job_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  rx_byte;
      logic [2:0]  channel;
      logic [15:0] pwm_value;
   } req_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] tx_byte;
      logic [2:0] event_res;
      logic [7:0] event_opcode;
      logic [7:0] event_param;
      logic       last;
   } rsp_type;

   // Queue status seen by the front end and the back end.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/spl_front.sv =====
`default_nettype none
// ============================================================================
// spl_front: receive framing and item classification
// Accepts one transaction per cycle while the queue has room, tracks the
// STX/ETX framing of received bytes and makes transmit jobs for the back end.
// ============================================================================
module spl_front #(
   parameter int NUM_CHANNELS = 6
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  spl_pkg::req_type           req_payload,
   input  spl_pkg::queue_status_type  q_status,
   output logic                       push,
   output spl_pkg::job_type           job
);
   import spl_pkg::*;

   link_state_type state_ff, state_in;
   logic [2:0]     count_ff, count_in;
   logic           peer_ff, peer_in;
   logic [7:0]     frame_ff [4];

   logic       take;
   logic       rx_take;
   logic       at_etx;
   logic       etx_ok;
   logic       sum_ok;
   logic       job_valid;
   logic [7:0] rx;

   // An item is taken whenever the queue has room.
   assign req_stall = q_status.full;
   assign take      = req_valid && !q_status.full;
   assign rx        = req_payload.rx_byte;
   assign rx_take   = take && (req_payload.action == ACT_RX);
   assign at_etx    = (state_ff == ST_COLLECT) && (count_ff == FRAME_DATA);
   assign etx_ok    = (rx == SYM_ETX);
   assign sum_ok    = (8'(frame_ff[0] + frame_ff[1] + frame_ff[2]) == frame_ff[3]);
   assign push      = take && job_valid;

   // Next framing state.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      peer_in  = peer_ff;
      if (rx_take) begin
         unique case (state_ff)
            ST_HUNT: begin
               if (rx == SYM_STX) begin
                  state_in = ST_COLLECT;
                  count_in = '0;
               end
            end
            ST_COLLECT: begin
               if (count_ff != FRAME_DATA) begin
                  count_in = count_ff + 3'd1;
               end else begin
                  state_in = ST_HUNT;
                  count_in = '0;
                  if (etx_ok && sum_ok) begin
                     peer_in = 1'b1;
                  end
               end
            end
            default: begin
               state_in = ST_HUNT;
            end
         endcase
      end
   end

   // Job produced by the current item.
   always_comb begin
      job_valid = 1'b0;
      job.kind  = JOB_EVENT;
      job.res   = EV_NONE;
      job.p1    = '0;
      job.p2    = '0;
      job.cmd   = '0;
      unique case (req_payload.action)
         ACT_RX: begin
            if (state_ff == ST_HUNT) begin
               if (rx != SYM_STX && rx != SYM_DLE) begin
                  job_valid = 1'b1;
                  job.res   = EV_SYNC;
               end
            end else if (at_etx) begin
               if (!etx_ok) begin
                  job_valid = 1'b1;
                  job.res   = EV_FRAME;
                  if (peer_ff) begin
                     job.kind = JOB_PACKET;
                     job.p1   = ERR_MALFORMED;
                     job.cmd  = CMD_ERROR;
                  end
               end else if (!sum_ok) begin
                  job_valid = 1'b1;
                  job.kind  = JOB_PACKET;
                  job.res   = EV_CSUM;
                  job.p1    = ERR_MALFORMED;
                  job.cmd   = CMD_ERROR;
               end else if (frame_ff[2] == CMD_ERROR) begin
                  job_valid = 1'b1;
                  job.kind  = JOB_PAD;
                  job.res   = EV_PEER;
                  job.p1    = frame_ff[0];
                  job.p2    = frame_ff[1];
               end else if (frame_ff[2] != CMD_HEARTBEAT && frame_ff[2] != CMD_ECHO) begin
                  job_valid = 1'b1;
                  job.res   = EV_UNKNOWN;
               end
            end
         end
         ACT_PWM: begin
            if (req_payload.channel < 3'(NUM_CHANNELS)) begin
               job_valid = 1'b1;
               job.kind  = JOB_PACKET;
               job.p1    = req_payload.pwm_value[15:8];
               job.p2    = req_payload.pwm_value[7:0];
               job.cmd   = CMD_PWM_FIRST + {5'd0, req_payload.channel};
            end
         end
         ACT_BEAT: begin
            job_valid = 1'b1;
            job.kind  = JOB_PACKET;
            job.cmd   = CMD_HEARTBEAT;
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
   end

   // Framing state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         count_ff <= '0;
         peer_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         peer_ff  <= peer_in;
      end
   end

   // Collected payload bytes of the packet in progress.
   always_ff @(posedge clock) begin
      if (rx_take && state_ff == ST_COLLECT && !count_ff[2]) begin
         frame_ff[count_ff[1:0]] <= rx;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/spl_queue.sv =====
`default_nettype none
// ============================================================================
// spl_queue: two-entry job queue
// Decouples the receive front end from the transmit back end so that each
// side stalls on its own.
// ============================================================================
module spl_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  spl_pkg::job_type           push_job,
   input  wire                        pop,
   output spl_pkg::job_type           head,
   output spl_pkg::queue_status_type  status
);
   import spl_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/spl_back.sv =====
`default_nettype none
// ============================================================================
// spl_back: transmit sequencer
// Takes jobs from the queue and sends their results, one per cycle while
// rsp_stall does not hold the output, through an output register.
// ============================================================================
module spl_back (
   input  wire                        clock,
   input  wire                        reset,
   input  spl_pkg::job_type           q_head,
   input  spl_pkg::queue_status_type  q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output spl_pkg::rsp_type           rsp_payload
);
   import spl_pkg::*;

   job_type    cur_ff;
   logic       active_ff, active_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;

   job_type    src;
   logic       have;
   logic       adv;
   logic       fire;
   logic       is_last;
   logic [7:0] sum;

   // The running job, or else the queue head, feeds the output.
   assign src     = active_ff ? cur_ff : q_head;
   assign have    = active_ff || !q_status.empty;
   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign fire    = adv && have;
   assign is_last = (src.kind == JOB_EVENT) || (idx_ff == POS_LAST);
   assign pop     = fire && !active_ff;
   assign sum     = 8'(src.p1 + src.p2 + src.cmd);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Result for the current byte position.
   always_comb begin
      rsp_in.has_byte     = (src.kind != JOB_EVENT);
      rsp_in.event_res    = src.res;
      rsp_in.event_opcode = (src.kind == JOB_PAD) ? src.p1 : 8'd0;
      rsp_in.event_param  = (src.kind == JOB_PAD) ? src.p2 : 8'd0;
      rsp_in.last         = is_last;
      rsp_in.tx_byte      = '0;
      case (src.kind)
         JOB_PAD: begin
            rsp_in.tx_byte = SYM_DLE;
         end
         JOB_PACKET: begin
            case (idx_ff)
               POS_STX: rsp_in.tx_byte = SYM_STX;
               POS_P1:  rsp_in.tx_byte = src.p1;
               POS_P2:  rsp_in.tx_byte = src.p2;
               POS_CMD: rsp_in.tx_byte = src.cmd;
               POS_SUM: rsp_in.tx_byte = sum;
               default: rsp_in.tx_byte = SYM_ETX;
            endcase
         end
         default: begin
            rsp_in.tx_byte = '0;
         end
      endcase
   end

   // Sequencer next state.
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      if (fire) begin
         if (is_last) begin
            active_in = 1'b0;
            idx_in    = '0;
         end else begin
            active_in = 1'b1;
            idx_in    = idx_ff + 3'd1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         if (adv) begin
            rsp_valid_ff <= have;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_head;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/stx_etx_packet_link.sv =====
`default_nettype none
// ============================================================================
// stx_etx_packet_link: link end of a six-byte STX/ETX serial framing
// Top level joining the receive front end, the job queue and the transmit
// back end.
// ============================================================================
// An input transaction can be accepted in every cycle while the two-entry job
// queue has room; items that produce no result (padding, STX, collected bytes,
// good heartbeat or echo packets, out-of-range channels) never occupy it. The
// transmit sequencer sends one result per cycle while rsp_stall does not hold
// it back: a framed packet or the DLE padding answer is six results, an
// event-only result is one. Results of back-to-back jobs follow each other
// without gaps. A result waiting on rsp_stall blocks input only once two
// further result-producing jobs wait in the queue behind the running one.
module stx_etx_packet_link #(
   parameter int NUM_CHANNELS = 6
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  spl_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output spl_pkg::rsp_type  rsp_payload
);
   import spl_pkg::*;

   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          q_head;
   queue_status_type q_status;

   spl_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .job         (push_job)
   );

   spl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (q_head),
      .status   (q_status)
   );

   spl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // The queue is never written while full.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("job queue written while full");

   // A job is never taken from an empty queue.
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("job queue read while empty");

   // Within one job the results follow without a gap and keep the event code.
   a_job_contiguous : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_payload.last)
         |=> (rsp_valid && $stable(rsp_payload.event_res)))
      else $error("result transaction sequence broken inside a job");

endmodule
`default_nettype wire

// ===== dv/stx_etx_packet_link_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stx_etx_packet_link_test: self-checking bench of the STX/ETX packet link
// Feeds received bytes, PWM set and heartbeat transactions into the input
// channel, predicts every outgoing byte and event with its own model of the
// framing, and checks each result transaction in order under random idling,
// stall bursts and one long receiver hold-off that backs up the job queue.
// ============================================================================
module stx_etx_packet_link_test;
   import spl_pkg::*;

   localparam int NUM_CHANNELS   = 6;
   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 6;
   localparam int TOTAL_ITEMS    = 450;
   localparam int QUIET_ITEMS    = 60;
   localparam int HOLD_AT        = 150;
   localparam int HOLD_CYCLES    = 120;
   localparam int DRAIN_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // The one action code that the block ignores.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      FLAW_NONE,
      FLAW_SUM,
      FLAW_ETX
   } frame_flaw_type;

   // Scoreboard: tracks the receive framing state and holds the results that
   // the link is due to send, oldest first.
   class link_scoreboard;
      rsp_type     link_results[$];
      logic        in_frame;
      logic [2:0]  fill;
      logic [7:0]  frame_data[4];
      logic        peer_seen;
      int unsigned mismatches;
      int unsigned checked;
      int unsigned event_hits[6];

      function new();
         in_frame   = 1'b0;
         fill       = '0;
         peer_seen  = 1'b0;
         mismatches = 0;
         checked    = 0;
         foreach (frame_data[i]) frame_data[i] = '0;
         foreach (event_hits[i]) event_hits[i] = 0;
      endfunction

      function void push_result(logic has, logic [7:0] tx, logic [2:0] res,
                                logic [7:0] op, logic [7:0] par, logic is_last);
         rsp_type r;
         r.has_byte     = has;
         r.tx_byte      = tx;
         r.event_res    = res;
         r.event_opcode = op;
         r.event_param  = par;
         r.last         = is_last;
         link_results.push_back(r);
      endfunction

      // A full six-byte packet with its additive checksum.
      function void push_packet(logic [7:0] cmd, logic [7:0] p1, logic [7:0] p2,
                                logic [2:0] res);
         logic [7:0] bytes_out[6];
         bytes_out[POS_STX]  = SYM_STX;
         bytes_out[POS_P1]   = p1;
         bytes_out[POS_P2]   = p2;
         bytes_out[POS_CMD]  = cmd;
         bytes_out[POS_SUM]  = p1 + p2 + cmd;
         bytes_out[POS_LAST] = SYM_ETX;
         event_hits[res]++;
         for (int i = 0; i < 6; i++)
            push_result(1'b1, bytes_out[i], res, 8'd0, 8'd0, i == POS_LAST);
      endfunction

      function void push_event(logic [2:0] res);
         event_hits[res]++;
         push_result(1'b0, 8'd0, res, 8'd0, 8'd0, 1'b1);
      endfunction

      // Receive side: hunt for STX, collect four bytes, then judge the fifth.
      function void take_byte(logic [7:0] b);
         logic [7:0] sum;
         if (!in_frame) begin
            if (b == SYM_STX) begin
               in_frame = 1'b1;
               fill     = '0;
            end else if (b != SYM_DLE) begin
               push_event(EV_SYNC);
            end
         end else if (fill < FRAME_DATA) begin
            frame_data[fill[1:0]] = b;
            fill++;
         end else begin
            in_frame = 1'b0;
            fill     = '0;
            sum      = frame_data[0] + frame_data[1] + frame_data[2];
            if (b != SYM_ETX) begin
               if (peer_seen)
                  push_packet(CMD_ERROR, ERR_MALFORMED, 8'd0, EV_FRAME);
               else
                  push_event(EV_FRAME);
            end else if (sum != frame_data[3]) begin
               push_packet(CMD_ERROR, ERR_MALFORMED, 8'd0, EV_CSUM);
            end else begin
               peer_seen = 1'b1;
               if (frame_data[2] == CMD_ERROR) begin
                  // A peer error report is answered with six padding bytes.
                  event_hits[EV_PEER]++;
                  for (int i = 0; i < 6; i++)
                     push_result(1'b1, SYM_DLE, EV_PEER, frame_data[0], frame_data[1],
                                 i == POS_LAST);
               end else if (frame_data[2] != CMD_HEARTBEAT && frame_data[2] != CMD_ECHO) begin
                  push_event(EV_UNKNOWN);
               end
            end
         end
      endfunction

      function void note_request(req_type item);
         case (item.action)
            ACT_RX: begin
               take_byte(item.rx_byte);
            end
            ACT_PWM: begin
               if (item.channel < NUM_CHANNELS)
                  push_packet(CMD_PWM_FIRST + item.channel, item.pwm_value[15:8],
                              item.pwm_value[7:0], EV_NONE);
            end
            ACT_BEAT: begin
               push_packet(CMD_HEARTBEAT, 8'd0, 8'd0, EV_NONE);
            end
            default: begin
            end
         endcase
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (link_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with nothing pending: has=%0d byte=%0d ev=%0d last=%0d",
                        $time, got.has_byte, got.tx_byte, got.event_res, got.last);
            return;
         end
         want = link_results.pop_front();
         checked++;
         if (got.has_byte !== want.has_byte || got.tx_byte !== want.tx_byte ||
             got.event_res !== want.event_res || got.event_opcode !== want.event_opcode ||
             got.event_param !== want.event_param || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: mismatch on result %0d", $time, checked);
               $display("   expected has=%0d byte=%0d ev=%0d op=%0d par=%0d last=%0d",
                        want.has_byte, want.tx_byte, want.event_res, want.event_opcode,
                        want.event_param, want.last);
               $display("   actual   has=%0d byte=%0d ev=%0d op=%0d par=%0d last=%0d",
                        got.has_byte, got.tx_byte, got.event_res, got.event_opcode,
                        got.event_param, got.last);
            end
         end
      endfunction
   endclass

   logic           clock        = 1'b0;
   logic           reset        = 1'b1;
   logic           req_valid    = 1'b0;
   logic           req_stall;
   req_type        req_payload  = '0;
   logic           rsp_valid;
   logic           rsp_stall    = 1'b0;
   rsp_type        rsp_payload;
   logic           quiet_phase  = 1'b0;
   logic           hold_request = 1'b0;
   int unsigned    sent_count   = 0;
   int unsigned    idle_cycles  = 0;
   link_scoreboard link_check   = new();

   stx_etx_packet_link #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Offer one transaction, with an optional idle burst first, and wait until
   // it is taken. Ignored items are not counted toward the run length.
   task automatic send_item(input req_type item);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!(item.action == ACT_UNUSED ||
            (item.action == ACT_PWM && item.channel >= NUM_CHANNELS)))
         sent_count++;
   endtask

   // Random filler in the fields that the chosen action does not use.
   function automatic req_type make_req(input logic [1:0] action);
      req_type r;
      r.action    = action;
      r.rx_byte   = 8'($urandom);
      r.channel   = 3'($urandom);
      r.pwm_value = 16'($urandom);
      return r;
   endfunction

   task automatic send_rx(input logic [7:0] b);
      req_type item;
      item         = make_req(ACT_RX);
      item.rx_byte = b;
      send_item(item);
   endtask

   task automatic send_pwm(input logic [2:0] ch, input logic [15:0] value);
      req_type item;
      item           = make_req(ACT_PWM);
      item.channel   = ch;
      item.pwm_value = value;
      send_item(item);
   endtask

   task automatic send_beat();
      send_item(make_req(ACT_BEAT));
   endtask

   // Send a whole frame byte by byte; when mixed, local PWM or heartbeat
   // transactions may slip in between the received bytes.
   task automatic send_frame(input logic [7:0] p1, input logic [7:0] p2,
                             input logic [7:0] cmd, input frame_flaw_type flaw,
                             input logic mixed);
      logic [7:0] sum;
      logic [7:0] tail;
      logic [7:0] body[5];
      sum = p1 + p2 + cmd;
      if (flaw == FLAW_SUM) sum = sum + 8'($urandom_range(1, 255));
      tail = SYM_ETX;
      if (flaw == FLAW_ETX) begin
         tail = 8'($urandom);
         if (tail == SYM_ETX) tail = ~tail;
      end
      body = '{p1, p2, cmd, sum, tail};
      send_rx(SYM_STX);
      foreach (body[i]) begin
         if (mixed && $urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0)
               send_pwm(3'($urandom_range(0, NUM_CHANNELS - 1)), 16'($urandom));
            else
               send_beat();
         end
         send_rx(body[i]);
      end
   endtask

   // Commands biased toward the ones with their own behavior.
   function automatic logic [7:0] random_command();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return CMD_HEARTBEAT;
      if (pick == 1) return CMD_ECHO;
      if (pick <= 3) return CMD_ERROR;
      if (pick <= 6) return CMD_PWM_FIRST + 8'($urandom_range(0, NUM_CHANNELS - 1));
      return 8'($urandom);
   endfunction

   // Monitor: checks results, predicts from accepted inputs, and watches for
   // a link that has stopped moving.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) link_check.check_response(rsp_payload);
         if (req_valid && !req_stall) link_check.note_request(req_payload);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results pending",
                     idle_cycles, link_check.link_results.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Receiver: short stall bursts, plus one long hold-off so that the job
   // queue fills and the input channel stalls.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Main sequence: reset, directed cases, then random traffic.
   initial begin
      req_type        item;
      int unsigned    pick;
      int unsigned    n;
      frame_flaw_type flaw;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Hunting: out-of-sync bytes at both ends of the range, padding skipped.
      send_rx(8'h00);
      send_rx(SYM_DLE);
      send_rx(8'hFF);
      // Local packets, PWM value extremes, and the ignored items.
      send_beat();
      send_pwm(3'd0, 16'hFFFF);
      send_pwm(3'd5, 16'h0000);
      item         = make_req(ACT_PWM);
      item.channel = 3'd7;
      send_item(item);
      send_item(make_req(ACT_UNUSED));
      // Frame error before any good packet, then a good error report that
      // carries STX as data, then a checksum error.
      send_frame(8'h00, 8'h00, CMD_ECHO, FLAW_ETX, 1'b0);
      send_frame(SYM_STX, 8'hFF, CMD_ERROR, FLAW_NONE, 1'b0);
      send_frame(8'h80, 8'h7F, 8'h05, FLAW_SUM, 1'b0);

      while (sent_count < TOTAL_ITEMS) begin
         if (sent_count >= HOLD_AT) hold_request <= 1'b1;
         if (sent_count >= TOTAL_ITEMS - QUIET_ITEMS) quiet_phase <= 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            n    = $urandom_range(0, 9);
            flaw = (n < 6) ? FLAW_NONE : (n < 8) ? FLAW_SUM : FLAW_ETX;
            send_frame(8'($urandom), 8'($urandom), random_command(), flaw, 1'b1);
         end else if (pick < 62) begin
            send_pwm(3'($urandom_range(0, NUM_CHANNELS - 1)), 16'($urandom));
         end else if (pick < 70) begin
            send_beat();
         end else if (pick < 80) begin
            // Line noise between frames.
            n = $urandom_range(0, 2);
            send_rx(n == 0 ? SYM_DLE : n == 1 ? SYM_STX : 8'($urandom));
         end else if (pick < 86) begin
            // A frame cut short; what follows lands in its data bytes.
            send_rx(SYM_STX);
            repeat ($urandom_range(1, 4)) send_rx(8'($urandom));
         end else if (pick < 92) begin
            if ($urandom_range(0, 1) == 0) begin
               item = make_req(ACT_UNUSED);
            end else begin
               item         = make_req(ACT_PWM);
               item.channel = 3'($urandom_range(NUM_CHANNELS, 7));
            end
            send_item(item);
         end else begin
            send_item(make_req(2'($urandom)));
         end
      end
      req_valid <= 1'b0;

      while (link_check.link_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d counted input transactions, %0d results checked, %0d mismatches.",
               sent_count, link_check.checked, link_check.mismatches);
      $display("Answers: sync %0d, frame %0d, checksum %0d, peer %0d, unknown %0d, local %0d.",
               link_check.event_hits[EV_SYNC], link_check.event_hits[EV_FRAME],
               link_check.event_hits[EV_CSUM], link_check.event_hits[EV_PEER],
               link_check.event_hits[EV_UNKNOWN], link_check.event_hits[EV_NONE]);
      if (link_check.mismatches == 0 && link_check.link_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/spl_pkg.sv
rtl/core/spl_front.sv
rtl/core/spl_queue.sv
rtl/core/spl_back.sv
rtl/core/stx_etx_packet_link.sv
dv/stx_etx_packet_link_test.sv
